// ----- design/scu_pkg.sv -----
`timescale 1ns / 1ps

package scu_pkg;

	// register file and word geometry
	localparam int REGISTER_COUNT = 8;
	localparam int REG_IDX_W      = $clog2(REGISTER_COUNT);
	localparam int DATA_W         = 32;
	localparam int COUNT_MODULUS  = 64;
	localparam int COUNT_W        = $clog2(COUNT_MODULUS);
	localparam int OPCODE_W       = 16;

	// operand size codes from opcode bits 7:6
	localparam logic [1:0] SIZE_BYTE  = 2'd0;
	localparam logic [1:0] SIZE_WORD  = 2'd1;
	localparam logic [1:0] SIZE_LONG  = 2'd2;
	localparam logic [1:0] SIZE_BAD   = 2'd3;

	// item commands
	localparam logic CMD_SHIFT = 1'b0;
	localparam logic CMD_LOAD  = 1'b1;

	// immediate count field of zero stands for eight
	localparam logic [COUNT_W-1:0] IMM_ZERO_COUNT = COUNT_W'(8);

	// flag positions in the condition code register
	localparam int FLAG_X = 4;
	localparam int FLAG_N = 3;
	localparam int FLAG_Z = 2;
	localparam int FLAG_V = 1;
	localparam int FLAG_C = 0;

	// control for one single-bit shift step
	typedef struct packed {
		logic [1:0] size;
		logic       shift_right;
		logic       logical_shift;
	} step_ctl_t;

	// mask of the sized operand
	function automatic logic [DATA_W-1:0] size_mask(input logic [1:0] size);
		logic [DATA_W-1:0] m;
		case (size)
			SIZE_BYTE: m = 32'h0000_00ff;
			SIZE_WORD: m = 32'h0000_ffff;
			default:   m = 32'hffff_ffff;
		endcase
		return m;
	endfunction

	// sign bit position of the sized operand, as a one-hot word
	function automatic logic [DATA_W-1:0] size_msb(input logic [1:0] size);
		logic [DATA_W-1:0] m;
		case (size)
			SIZE_BYTE: m = 32'h0000_0080;
			SIZE_WORD: m = 32'h0000_8000;
			default:   m = 32'h8000_0000;
		endcase
		return m;
	endfunction

endpackage

// ----- design/shift_unit_with_condition_codes.sv -----
`timescale 1ns / 1ps

// Shift unit with eight 32-bit data registers and X N Z V C flags. Each input
// word is either a load (writes one data register, flags untouched) or an
// ASL/ASR/LSL/LSR shift of the byte, word or long of a target register, with a
// count from the opcode (0 means 8) or from a data register modulo 64. One
// result word comes back per input word. A single one-bit shifter is reused
// once per count step (count 0 to 63); a register count is read in a state of
// its own, and a load or a size-3 shift does not use the shifter.
// One word is worked on at a time; a new word is accepted while the previous
// result still waits in the output register. Registers read as zero after
// reset until written.

module shift_unit_with_condition_codes import scu_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                command,
	input  logic [OPCODE_W-1:0] opcode,
	input  logic                shift_right,
	input  logic                logical_shift,
	input  logic [REG_IDX_W-1:0] load_index,
	input  logic [DATA_W-1:0]   load_value,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [DATA_W-1:0]   result_value,
	output logic                flag_x,
	output logic                flag_n,
	output logic                flag_z,
	output logic                flag_v,
	output logic                flag_c,
	output logic                bad_size
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_TARGET,
		S_COUNT,
		S_SHIFT,
		S_WRITE,
		S_FINISH
	} state_t;

	state_t state_q;

	// latched input word
	logic                 command_q;
	logic [REG_IDX_W-1:0] target_q;
	logic [REG_IDX_W-1:0] field_q;
	logic                 cnt_from_reg_q;
	step_ctl_t            ctl_q;
	logic [REG_IDX_W-1:0] load_index_q;
	logic [DATA_W-1:0]    load_value_q;

	// working registers
	logic [DATA_W-1:0]    tgt_q;
	logic [DATA_W-1:0]    data_q;
	logic [COUNT_W-1:0]   cnt_q;
	logic                 cnt_nz_q;
	logic                 c_q;
	logic                 v_q;
	logic [4:0]           flags_q;
	logic [DATA_W-1:0]    res_value_q;
	logic                 res_bad_q;

	// output register
	logic                 out_valid_q;
	logic [DATA_W-1:0]    result_value_q;
	logic [4:0]           out_flags_q;
	logic                 bad_size_q;

	// register file valid bits
	logic [REGISTER_COUNT-1:0] reg_valid_q;
	logic [REG_IDX_W-1:0]      rd_addr_q;

	logic                 rf_we;
	logic [REG_IDX_W-1:0] rf_waddr;
	logic [DATA_W-1:0]    rf_wdata;
	logic [REG_IDX_W-1:0] rf_raddr;
	logic [DATA_W-1:0]    rf_rdata;
	logic [DATA_W-1:0]    rd_val;

	logic [DATA_W-1:0]    mask;
	logic [DATA_W-1:0]    msb;
	logic [DATA_W-1:0]    merged;
	logic                 res_n;
	logic                 res_z;
	logic                 res_v;

	logic [DATA_W-1:0]    step_data;
	logic                 step_carry;
	logic                 step_change;

	logic                 in_acc;
	logic                 out_free;
	logic                 out_load;

	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign out_load = (state_q == S_FINISH) && out_free;
	assign in_ready = state_q == S_IDLE;

	assign mask   = size_mask(ctl_q.size);
	assign msb    = size_msb(ctl_q.size);
	assign merged = (tgt_q & ~mask) | data_q;
	assign res_n  = |(data_q & msb);
	assign res_z  = data_q == '0;
	assign res_v  = v_q && !ctl_q.shift_right && !ctl_q.logical_shift;

	// register file read address: target first, count register next
	assign rf_raddr = (state_q == S_TARGET) ? field_q : target_q;
	assign rd_val   = reg_valid_q[rd_addr_q] ? rf_rdata : '0;

	// register file writes for loads and shift writeback
	always_comb begin
		rf_we    = 1'b0;
		rf_waddr = target_q;
		rf_wdata = merged;
		if (state_q == S_DECODE && command_q == CMD_LOAD) begin
			rf_we    = 1'b1;
			rf_waddr = load_index_q;
			rf_wdata = load_value_q;
		end else if (state_q == S_WRITE) begin
			rf_we = 1'b1;
		end
	end

	scu_ram #(
		.WIDTH(DATA_W),
		.DEPTH(REGISTER_COUNT)
	) u_regfile (
		.clk   (clk),
		.we    (rf_we),
		.waddr (rf_waddr),
		.wdata (rf_wdata),
		.raddr (rf_raddr),
		.rdata (rf_rdata)
	);

	scu_shift_step u_step (
		.ctl         (ctl_q),
		.data_in     (data_q),
		.data_out    (step_data),
		.carry       (step_carry),
		.sign_change (step_change)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			command_q      <= CMD_SHIFT;
			target_q       <= '0;
			field_q        <= '0;
			cnt_from_reg_q <= 1'b0;
			ctl_q          <= '0;
			load_index_q   <= '0;
			load_value_q   <= '0;
			tgt_q          <= '0;
			data_q         <= '0;
			cnt_q          <= '0;
			cnt_nz_q       <= 1'b0;
			c_q            <= 1'b0;
			v_q            <= 1'b0;
			flags_q        <= '0;
			res_value_q    <= '0;
			res_bad_q      <= 1'b0;
			out_valid_q    <= 1'b0;
			result_value_q <= '0;
			out_flags_q    <= '0;
			bad_size_q     <= 1'b0;
			reg_valid_q    <= '0;
			rd_addr_q      <= '0;
		end else begin
			rd_addr_q <= rf_raddr;
			if (rf_we) begin
				reg_valid_q[rf_waddr] <= 1'b1;
			end
			// output word valid: set on handover, cleared when taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						command_q         <= command;
						target_q          <= opcode[2:0];
						field_q           <= opcode[11:9];
						cnt_from_reg_q    <= opcode[5];
						ctl_q.size        <= opcode[7:6];
						ctl_q.shift_right <= shift_right;
						ctl_q.logical_shift <= logical_shift;
						load_index_q      <= load_index;
						load_value_q      <= load_value;
						state_q           <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (command_q == CMD_LOAD) begin
						res_value_q <= load_value_q;
						res_bad_q   <= 1'b0;
						state_q     <= S_FINISH;
					end else begin
						state_q <= S_TARGET;
					end
				end
				S_TARGET: begin
					tgt_q  <= rd_val;
					data_q <= rd_val & mask;
					c_q    <= 1'b0;
					v_q    <= 1'b0;
					if (ctl_q.size == SIZE_BAD) begin
						res_value_q <= rd_val;
						res_bad_q   <= 1'b1;
						state_q     <= S_FINISH;
					end else if (cnt_from_reg_q) begin
						state_q <= S_COUNT;
					end else begin
						cnt_q    <= (field_q == '0) ? IMM_ZERO_COUNT : COUNT_W'(field_q);
						cnt_nz_q <= 1'b1;
						state_q  <= S_SHIFT;
					end
				end
				S_COUNT: begin
					cnt_q    <= rd_val[COUNT_W-1:0];
					cnt_nz_q <= rd_val[COUNT_W-1:0] != '0;
					state_q  <= S_SHIFT;
				end
				S_SHIFT: begin
					// one bit per cycle through the shared step unit
					if (cnt_q == '0) begin
						state_q <= S_WRITE;
					end else begin
						data_q <= step_data;
						c_q    <= step_carry;
						v_q    <= v_q | step_change;
						cnt_q  <= cnt_q - COUNT_W'(1);
					end
				end
				S_WRITE: begin
					flags_q[FLAG_X] <= cnt_nz_q ? c_q : flags_q[FLAG_X];
					flags_q[FLAG_N] <= res_n;
					flags_q[FLAG_Z] <= res_z;
					flags_q[FLAG_V] <= res_v;
					flags_q[FLAG_C] <= c_q;
					res_value_q     <= merged;
					res_bad_q       <= 1'b0;
					state_q         <= S_FINISH;
				end
				S_FINISH: begin
					// hand the word over once the output register is free
					if (out_free) begin
						result_value_q <= res_value_q;
						out_flags_q    <= flags_q;
						bad_size_q     <= res_bad_q;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = result_value_q;
	assign flag_x       = out_flags_q[FLAG_X];
	assign flag_n       = out_flags_q[FLAG_N];
	assign flag_z       = out_flags_q[FLAG_Z];
	assign flag_v       = out_flags_q[FLAG_V];
	assign flag_c       = out_flags_q[FLAG_C];
	assign bad_size     = bad_size_q;

endmodule

// ----- design/scu_ram.sv -----
`timescale 1ns / 1ps

module scu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- design/scu_shift_step.sv -----
`timescale 1ns / 1ps

module scu_shift_step import scu_pkg::*; (
	input  step_ctl_t         ctl,
	input  logic [DATA_W-1:0] data_in,
	output logic [DATA_W-1:0] data_out,
	output logic              carry,
	output logic              sign_change
);

	logic [DATA_W-1:0] mask;
	logic [DATA_W-1:0] msb;
	logic              msb_in;
	logic [DATA_W-1:0] left_val;
	logic [DATA_W-1:0] right_val;

	assign mask   = size_mask(ctl.size);
	assign msb    = size_msb(ctl.size);
	assign msb_in = |(data_in & msb);

	// left fills with zero, right fills with sign for arithmetic
	assign left_val  = (data_in << 1) & mask;
	assign right_val = (data_in >> 1) | ((msb_in && !ctl.logical_shift) ? msb : '0);

	// one bit of shift, carry is the bit pushed out
	always_comb begin
		if (ctl.shift_right) begin
			data_out    = right_val;
			carry       = data_in[0];
			sign_change = 1'b0;
		end else begin
			data_out    = left_val;
			carry       = msb_in;
			sign_change = msb_in != (|(left_val & msb));
		end
	end

endmodule

// ----- dv/shift_unit_with_condition_codes_tb.sv -----
`timescale 1ns / 1ps

module shift_unit_with_condition_codes_tb;
	import scu_pkg::*;

	localparam int RANDOM_WORDS   = 1450;
	localparam int SETTLE_CYCLES  = 100;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 300;
	localparam int MAX_PRINTED    = 100;

	// receiver stall styles
	typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

	// one input word plus a flag that makes the sender wait for an empty pipe
	typedef struct packed {
		logic                 command;
		logic [OPCODE_W-1:0]  opcode;
		logic                 shift_right;
		logic                 logical_shift;
		logic [REG_IDX_W-1:0] load_index;
		logic [DATA_W-1:0]    load_value;
		logic                 drain;
	} word_t;

	// register content and flags after one word
	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              x;
		logic              n;
		logic              z;
		logic              v;
		logic              c;
		logic              bad;
	} outcome_t;

	logic                 clk;
	logic                 arst_n        = 1'b0;
	logic                 in_valid      = 1'b0;
	logic                 in_ready;
	logic                 command       = CMD_SHIFT;
	logic [OPCODE_W-1:0]  opcode        = '0;
	logic                 shift_right   = 1'b0;
	logic                 logical_shift = 1'b0;
	logic [REG_IDX_W-1:0] load_index    = '0;
	logic [DATA_W-1:0]    load_value    = '0;
	logic                 out_valid;
	logic                 out_ready     = 1'b0;
	logic [DATA_W-1:0]    result_value;
	logic                 flag_x;
	logic                 flag_n;
	logic                 flag_z;
	logic                 flag_v;
	logic                 flag_c;
	logic                 bad_size;

	shift_unit_with_condition_codes dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.opcode       (opcode),
		.shift_right  (shift_right),
		.logical_shift(logical_shift),
		.load_index   (load_index),
		.load_value   (load_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_value (result_value),
		.flag_x       (flag_x),
		.flag_n       (flag_n),
		.flag_z       (flag_z),
		.flag_v       (flag_v),
		.flag_c       (flag_c),
		.bad_size     (bad_size)
	);

	word_t             pending_words[$];
	outcome_t          shift_outcomes[$];
	logic [DATA_W-1:0] shadow_regs[REGISTER_COUNT];
	logic [4:0]        shadow_flags;
	int                error_count    = 0;
	int                words_accepted = 0;
	int                total_words    = 0;
	int                idle_cycles    = 0;

	// sender state
	word_t offered;
	int    gap_left   = 0;
	int    burst_left = 0;
	logic  next_valid;

	// receiver state
	rx_mode_t rx_mode    = RX_ALWAYS;
	int       rx_cycle   = 0;
	int       hold_left  = 0;
	int       words_seen = 0;
	outcome_t want;

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// one line per mismatch, printing capped, counting not
	task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] wanted);
		error_count++;
		if (error_count <= MAX_PRINTED)
			$display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, wanted);
	endtask

	// apply one word to the shadow registers and flags, queue what must come out
	task automatic predict_word(input word_t w);
		outcome_t          o;
		logic [2:0]        tgt;
		logic [2:0]        fld;
		logic [1:0]        sz;
		int unsigned       cnt;
		int unsigned       width;
		logic [DATA_W-1:0] msk;
		logic [DATA_W-1:0] msb;
		logic [DATA_W-1:0] d;
		logic [DATA_W-1:0] fill;
		logic              cbit;
		logic              vbit;
		o     = '0;
		tgt   = w.opcode[2:0];
		sz    = w.opcode[7:6];
		fld   = w.opcode[11:9];
		if (w.command == CMD_LOAD) begin
			shadow_regs[w.load_index] = w.load_value;
			o.value = w.load_value;
		end else if (sz == SIZE_BAD) begin
			o.value = shadow_regs[tgt];
			o.bad   = 1'b1;
		end else begin
			// count from a register modulo 64, or an immediate where zero means eight
			if (w.opcode[5])
				cnt = 32'(shadow_regs[fld][COUNT_W-1:0]);
			else
				cnt = (fld == 3'd0) ? 32'd8 : 32'(fld);
			case (sz)
				SIZE_BYTE: width = 8;
				SIZE_WORD: width = 16;
				default:   width = 32;
			endcase
			msk  = (width == 32) ? '1 : ((32'd1 << width) - 32'd1);
			msb  = 32'd1 << (width - 1);
			d    = shadow_regs[tgt] & msk;
			cbit = 1'b0;
			vbit = 1'b0;
			// bit-serial shift, V only for arithmetic left
			if (w.shift_right) begin
				fill = w.logical_shift ? '0 : (d & msb);
				for (int i = 0; i < cnt; i++) begin
					cbit = d[0];
					d    = (d >> 1) | fill;
				end
			end else begin
				for (int i = 0; i < cnt; i++) begin
					cbit = |(d & msb);
					d    = (d << 1) & msk;
					if (cbit != |(d & msb))
						vbit = 1'b1;
				end
				if (w.logical_shift)
					vbit = 1'b0;
			end
			if (cnt != 0)
				shadow_flags[FLAG_X] = cbit;
			shadow_flags[FLAG_N] = |(d & msb);
			shadow_flags[FLAG_Z] = (d == '0);
			shadow_flags[FLAG_V] = vbit;
			shadow_flags[FLAG_C] = cbit;
			shadow_regs[tgt] = (shadow_regs[tgt] & ~msk) | d;
			o.value = shadow_regs[tgt];
		end
		o.x = shadow_flags[FLAG_X];
		o.n = shadow_flags[FLAG_N];
		o.z = shadow_flags[FLAG_Z];
		o.v = shadow_flags[FLAG_V];
		o.c = shadow_flags[FLAG_C];
		shift_outcomes.push_back(o);
	endtask

	// load word, ignored fields random
	function automatic word_t load_word(input logic [2:0] idx, input logic [DATA_W-1:0] val);
		word_t w;
		w.command       = CMD_LOAD;
		w.opcode        = OPCODE_W'($urandom);
		w.shift_right   = 1'($urandom);
		w.logical_shift = 1'($urandom);
		w.load_index    = idx;
		w.load_value    = val;
		w.drain         = 1'b0;
		return w;
	endfunction

	// shift word, opcode bits the block ignores random
	function automatic word_t shift_word(input logic [1:0] sz, input logic [2:0] fld,
			input logic from_reg, input logic [2:0] tgt, input logic right, input logic logical);
		word_t w;
		w.command       = CMD_SHIFT;
		w.opcode        = OPCODE_W'($urandom);
		w.opcode[2:0]   = tgt;
		w.opcode[5]     = from_reg;
		w.opcode[7:6]   = sz;
		w.opcode[11:9]  = fld;
		w.shift_right   = right;
		w.logical_shift = logical;
		w.load_index    = REG_IDX_W'($urandom);
		w.load_value    = $urandom;
		w.drain         = 1'b0;
		return w;
	endfunction

	// sender: bursts and gaps, optional wait for an empty pipe before a word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				predict_word(offered);
				words_accepted++;
			end
			if (!in_valid || in_ready) begin
				next_valid = 1'b0;
				if (gap_left != 0) begin
					gap_left--;
				end else if (pending_words.size() != 0 &&
						(!pending_words[0].drain || shift_outcomes.size() == 0)) begin
					offered       = pending_words.pop_front();
					next_valid    = 1'b1;
					command       <= offered.command;
					opcode        <= offered.opcode;
					shift_right   <= offered.shift_right;
					logical_shift <= offered.logical_shift;
					load_index    <= offered.load_index;
					load_value    <= offered.load_value;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 24);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
					end else begin
						burst_left--;
					end
				end
				in_valid <= next_valid;
			end
		end
	end

	// receiver: compare each word, then pick the next ready level
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready   <= 1'b0;
			idle_cycles <= 0;
		end else begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (out_valid && out_ready) begin
				words_seen++;
				if (shift_outcomes.size() == 0) begin
					report_mismatch("unexpected word", result_value, '0);
				end else begin
					want = shift_outcomes.pop_front();
					if (result_value !== want.value)
						report_mismatch("result_value", result_value, want.value);
					if (flag_x !== want.x)
						report_mismatch("flag_x", flag_x, want.x);
					if (flag_n !== want.n)
						report_mismatch("flag_n", flag_n, want.n);
					if (flag_z !== want.z)
						report_mismatch("flag_z", flag_z, want.z);
					if (flag_v !== want.v)
						report_mismatch("flag_v", flag_v, want.v);
					if (flag_c !== want.c)
						report_mismatch("flag_c", flag_c, want.c);
					if (bad_size !== want.bad)
						report_mismatch("bad_size", bad_size, want.bad);
				end
				// long hold-off so the block fills and stalls its input
				if (words_seen == 300 || words_seen == 1000)
					hold_left = HOLD_CYCLES;
			end
			rx_cycle++;
			if (rx_cycle % 400 == 0)
				rx_mode = rx_mode_t'($urandom_range(0, 2));
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_ALWAYS:  out_ready <= 1'b1;
					RX_RANDOM:  out_ready <= 1'($urandom_range(0, 1));
					default:    out_ready <= ((rx_cycle % 7) < 3);
				endcase
			end
		end
	end

	// watchdog on cycles with no word moving
	initial begin
		wait (arst_n === 1'b1);
		while (idle_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
		$display("shift_unit_with_condition_codes regression: fail");
		$finish;
	end

	// stimulus, reset and end of run
	initial begin
		word_t       w;
		logic [31:0] val;
		for (int i = 0; i < REGISTER_COUNT; i++)
			shadow_regs[i] = '0;
		shadow_flags = '0;

		// directed: register extremes, every shift kind, the special counts
		pending_words.push_back(load_word(3'd0, 32'h8000_0081));
		pending_words.push_back(load_word(3'd1, 32'hffff_ffff));
		pending_words.push_back(load_word(3'd2, 32'h0000_0000));
		pending_words.push_back(load_word(3'd3, 32'h0000_003f));
		pending_words.push_back(load_word(3'd4, 32'h7fff_ff40));
		pending_words.push_back(load_word(3'd5, 32'h0000_0005));
		pending_words.push_back(load_word(3'd6, 32'h5555_aaaa));
		pending_words.push_back(load_word(3'd7, 32'hffff_ffc1));
		// immediate zero means eight
		pending_words.push_back(shift_word(SIZE_BYTE, 3'd0, 1'b0, 3'd0, 1'b0, 1'b0));
		pending_words.push_back(shift_word(SIZE_WORD, 3'd1, 1'b0, 3'd1, 1'b1, 1'b0));
		// register count of 63, past the operand width
		pending_words.push_back(shift_word(SIZE_LONG, 3'd3, 1'b1, 3'd6, 1'b0, 1'b1));
		// register count of zero: carry clear, extend kept
		pending_words.push_back(shift_word(SIZE_BYTE, 3'd4, 1'b1, 3'd6, 1'b1, 1'b1));
		pending_words.push_back(shift_word(SIZE_BAD, 3'd5, 1'b1, 3'd7, 1'b0, 1'b0));
		// count register is the target itself
		pending_words.push_back(shift_word(SIZE_LONG, 3'd7, 1'b1, 3'd7, 1'b0, 1'b0));
		pending_words.push_back(shift_word(SIZE_LONG, 3'd3, 1'b1, 3'd0, 1'b1, 1'b0));
		pending_words.push_back(shift_word(SIZE_LONG, 3'd7, 1'b0, 3'd1, 1'b1, 1'b1));
		pending_words.push_back(shift_word(SIZE_WORD, 3'd3, 1'b0, 3'd5, 1'b0, 1'b1));
		pending_words.push_back(shift_word(SIZE_BYTE, 3'd1, 1'b0, 3'd5, 1'b0, 1'b0));
		pending_words.push_back(load_word(3'd7, 32'hffff_ffff));
		pending_words.push_back(shift_word(SIZE_WORD, 3'd7, 1'b1, 3'd2, 1'b1, 1'b0));
		pending_words.push_back(shift_word(SIZE_LONG, 3'd0, 1'b0, 3'd1, 1'b0, 1'b0));
		pending_words.push_back(shift_word(SIZE_BYTE, 3'd3, 1'b1, 3'd1, 1'b1, 1'b0));
		pending_words.push_back(shift_word(SIZE_BAD, 3'd2, 1'b0, 3'd4, 1'b1, 1'b1));

		// random mix of loads and shifts, a few waiting for an empty pipe
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if ($urandom_range(0, 99) < 22) begin
				case ($urandom_range(0, 4))
					0:       val = $urandom;
					1:       val = $urandom_range(0, 70);
					2:       val = {1'b1, 31'($urandom)};
					3:       val = '0;
					default: val = '1;
				endcase
				w = load_word(3'($urandom), val);
			end else begin
				w = shift_word(($urandom_range(0, 11) == 0) ? SIZE_BAD : 2'($urandom_range(0, 2)),
					3'($urandom), 1'($urandom), 3'($urandom), 1'($urandom), 1'($urandom));
			end
			w.drain = (i % 250 == 10);
			pending_words.push_back(w);
		end
		total_words = pending_words.size();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (words_accepted != total_words || shift_outcomes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (shift_outcomes.size() != 0)
			report_mismatch("words never returned", shift_outcomes.size(), '0);

		if (error_count == 0)
			$display("shift_unit_with_condition_codes regression: pass");
		else
			$display("shift_unit_with_condition_codes regression: fail");
		$finish;
	end

endmodule

// ----- shift_unit_with_condition_codes.f -----
design/scu_pkg.sv
design/scu_ram.sv
design/scu_shift_step.sv
design/shift_unit_with_condition_codes.sv
dv/shift_unit_with_condition_codes_tb.sv
